@@ design/sct_pkg.sv @@
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants
// Request codes, controller states and the command/status bundles that pass
// between the controller and the datapath of the coefficient table.
// ----------------------------------------------------------------------------
`default_nettype none

package sct_pkg;

	localparam int KEY_BITS    = 8;
	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int COEF_W      = 32;
	localparam int MOD_W       = 16;
	localparam int ODD_W       = 10;
	localparam int STEP_W      = $clog2(COEF_W);
	localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(8);

	typedef enum logic [2:0] {
		OP_ADD    = 3'd0,
		OP_SUB    = 3'd1,
		OP_SET    = 3'd2,
		OP_LOOKUP = 3'd3,
		OP_REDUCE = 3'd4,
		OP_CLEAN  = 3'd5,
		OP_CLEAR  = 3'd6,
		OP_ODD    = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EVAL,
		ST_DIV,
		ST_WB,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic eval;
		logic div_start;
		logic div_step;
		logic wb;
		logic fin;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic mod_zero;
		logic scan_done;
		logic hit;
		logic div_last;
	} stat_t;

endpackage

`default_nettype wire

@@ design/sct_ctrl.sv @@
// ----------------------------------------------------------------------------
// sct_ctrl: request sequencer
// Walks the stored terms one at a time and steps the residue unit for reduce.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire sct_pkg::op_t  req_op,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	input  wire sct_pkg::stat_t stat,
	output sct_pkg::cmd_t      cmd
);
	import sct_pkg::*;

	state_t state_q, state_nx;
	logic   m_tvalid_q;

	assign m_tvalid = m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_nx = (req_op == OP_CLEAR) ? ST_FIN : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.scan_done) begin
					state_nx = ST_FIN;
				end else begin
					cmd.rd   = 1'b1;
					state_nx = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				if ((stat.op == OP_ADD || stat.op == OP_SUB || stat.op == OP_SET) && stat.hit)
					state_nx = ST_FIN;
				else if (stat.op == OP_REDUCE && !stat.mod_zero) begin
					cmd.div_start = 1'b1;
					state_nx      = ST_DIV;
				end else
					state_nx = ST_SCAN;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last)
					state_nx = ST_WB;
			end
			ST_WB: begin
				cmd.wb   = 1'b1;
				state_nx = ST_SCAN;
			end
			ST_FIN: begin
				cmd.fin  = 1'b1;
				state_nx = ST_OUT;
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

@@ design/sct_dp.sv @@
// ----------------------------------------------------------------------------
// sct_dp: term store and arithmetic
// Key/coefficient memory, scan pointers, residue unit and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire sct_pkg::cmd_t                cmd,
	output sct_pkg::stat_t                    stat,
	input  wire sct_pkg::op_t                 req_op,
	input  wire logic [7:0]                   req_key,
	input  wire logic [sct_pkg::COEF_W-1:0]   req_value,
	input  wire logic                         cfg_valid,
	input  wire logic [sct_pkg::MOD_W-1:0]    cfg_data,
	output logic [sct_pkg::COEF_W-1:0]        out_coef,
	output logic [sct_pkg::ODD_W-1:0]         out_odd,
	output logic [sct_pkg::CNT_W-1:0]         out_cnt,
	output logic                              out_status
);
	import sct_pkg::*;

	logic [KEY_BITS-1:0] key_mem [TABLE_DEPTH];
	logic [COEF_W-1:0]   coef_mem [TABLE_DEPTH];

	op_t                 op_q;
	logic [KEY_BITS-1:0] key_q, rd_key_q;
	logic [COEF_W-1:0]   val_q, rd_coef_q, old_q, res_q, mag_q;
	logic [MOD_W-1:0]    mod_q, rem_q;
	logic [CNT_W-1:0]    count_q, t_q, w_q;
	logic [ADDR_W-1:0]   pos_q;
	logic [ODD_W-1:0]    odd_q;
	logic [STEP_W-1:0]   step_q;
	logic                found_q, status_q, neg_q;

	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	logic [KEY_BITS-1:0] wr_key;
	logic [COEF_W-1:0]   wr_coef;
	logic [COEF_W-1:0]   base, new_coef, red_val;
	logic [MOD_W:0]      trial, trial_sub;
	logic                upd_op, full, reduce_act, hit;

	assign upd_op     = (op_q == OP_ADD) || (op_q == OP_SUB) || (op_q == OP_SET);
	assign full       = (count_q == CNT_W'(TABLE_DEPTH));
	assign reduce_act = (op_q == OP_REDUCE) && (mod_q != '0);
	assign hit        = (rd_key_q == key_q);

	assign stat.op        = op_q;
	assign stat.mod_zero  = (mod_q == '0);
	assign stat.scan_done = (t_q == count_q);
	assign stat.hit       = hit;
	assign stat.div_last  = (step_q == STEP_W'(COEF_W - 1));

	assign base = found_q ? old_q : '0;
	always_comb begin
		case (op_q)
			OP_ADD:  new_coef = base + val_q;
			OP_SUB:  new_coef = base - val_q;
			default: new_coef = val_q;
		endcase
	end

	// restoring remainder step on the magnitude, one bit a cycle
	assign trial     = {rem_q, mag_q[COEF_W-1]};
	assign trial_sub = trial - {1'b0, mod_q};
	assign red_val   = COEF_W'((neg_q && rem_q != '0) ? (mod_q - rem_q) : rem_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_key  = key_q;
		wr_coef = new_coef;
		if (cmd.eval && op_q == OP_CLEAN && rd_coef_q != '0) begin
			wr_en   = 1'b1;
			wr_addr = w_q[ADDR_W-1:0];
			wr_key  = rd_key_q;
			wr_coef = rd_coef_q;
		end else if (cmd.wb) begin
			wr_en   = 1'b1;
			wr_addr = t_q[ADDR_W-1:0];
			wr_key  = rd_key_q;
			wr_coef = red_val;
		end else if (cmd.fin && upd_op) begin
			if (found_q) begin
				wr_en = 1'b1;
			end else if (!full) begin
				wr_en   = 1'b1;
				wr_addr = count_q[ADDR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr]  <= wr_key;
			coef_mem[wr_addr] <= wr_coef;
		end
		if (cmd.rd) begin
			rd_key_q  <= key_mem[t_q[ADDR_W-1:0]];
			rd_coef_q <= coef_mem[t_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mod_q   <= MOD_RESET;
		end else begin
			if (cfg_valid)
				mod_q <= cfg_data;
			if (cmd.fin) begin
				if (op_q == OP_CLEAN)
					count_q <= w_q;
				else if (op_q == OP_CLEAR)
					count_q <= '0;
				else if (upd_op && !found_q && !full)
					count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= req_op;
			key_q    <= req_key[KEY_BITS-1:0];
			val_q    <= req_value;
			t_q      <= '0;
			w_q      <= '0;
			found_q  <= 1'b0;
			status_q <= 1'b0;
			res_q    <= '0;
			odd_q    <= '0;
		end
		if (cmd.eval) begin
			if (upd_op && hit) begin
				found_q <= 1'b1;
				pos_q   <= t_q[ADDR_W-1:0];
				old_q   <= rd_coef_q;
			end
			if (!reduce_act && !(upd_op && hit))
				t_q <= t_q + 1'b1;
			if (hit && !reduce_act && !(op_q == OP_CLEAN && rd_coef_q == '0))
				res_q <= rd_coef_q;
			if (op_q == OP_CLEAN && rd_coef_q != '0)
				w_q <= w_q + 1'b1;
			if (op_q == OP_ODD && rd_key_q != '0 && rd_coef_q[0])
				odd_q <= rd_coef_q[COEF_W-1] ? odd_q - 1'b1 : odd_q + 1'b1;
		end
		if (cmd.div_start) begin
			neg_q  <= rd_coef_q[COEF_W-1];
			mag_q  <= rd_coef_q[COEF_W-1] ? (~rd_coef_q + 1'b1) : rd_coef_q;
			rem_q  <= '0;
			step_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= trial_sub[MOD_W] ? trial[MOD_W-1:0] : trial_sub[MOD_W-1:0];
			mag_q  <= {mag_q[COEF_W-2:0], 1'b0};
			step_q <= step_q + 1'b1;
		end
		if (cmd.wb) begin
			t_q <= t_q + 1'b1;
			if (hit)
				res_q <= red_val;
		end
		if (cmd.fin) begin
			if (op_q == OP_CLEAR)
				res_q <= '0;
			else if (upd_op) begin
				if (!found_q && full) begin
					status_q <= 1'b1;
					res_q    <= '0;
				end else
					res_q <= new_coef;
			end
		end
		if (cmd.out_load) begin
			out_coef   <= res_q;
			out_odd    <= odd_q;
			out_cnt    <= count_q;
			out_status <= status_q;
		end
	end

endmodule

`default_nettype wire

@@ design/sparse_coefficient_table.sv @@
// ----------------------------------------------------------------------------
// sparse_coefficient_table: ordered key/coefficient term table
// Up to 256 terms kept in insertion order, updated by streamed requests.
// ----------------------------------------------------------------------------
// Requests enter on the s_ side (kind in s_tuser, key and value in s_tdata),
// one result per request leaves on the m_ side. cfg_ writes the reduce
// modulus and is always ready; write it only while the block is idle.
// One request is worked at a time. Each request but clear scans the stored
// terms, reading each from the single-port term memory in the scan state
// and checking it in the eval state; add, subtract and set stop at the
// matching term. Reduce runs a one-bit-per-cycle remainder unit on every
// term while the modulus is nonzero. Clear skips the scan.
// The result sits in an output register: a new request is taken while it
// waits, and the block holds its next result until m_tready frees the slot.
// Reset empties the table and sets the modulus to 8; memory contents are not
// cleared, only the term count.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_coefficient_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // key[7:0], value[39:8]
	input  wire logic [2:0]  s_tuser,  // req_type[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,  // coefficient[31:0], odd_count[41:32],
	                                   // term_count[50:42], status[51], zero
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);
	import sct_pkg::*;

	cmd_t               cmd;
	stat_t              stat;
	op_t                req_op;
	logic [COEF_W-1:0]  out_coef;
	logic [ODD_W-1:0]   out_odd;
	logic [CNT_W-1:0]   out_cnt;
	logic               out_status;

	assign req_op    = op_t'(s_tuser);
	assign cfg_ready = 1'b1;
	assign m_tdata   = {4'b0, out_status, out_cnt, out_odd, out_coef};

	sct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.req_op   (req_op),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sct_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.req_op     (req_op),
		.req_key    (s_tdata[7:0]),
		.req_value  (s_tdata[39:8]),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.out_coef   (out_coef),
		.out_odd    (out_odd),
		.out_cnt    (out_cnt),
		.out_status (out_status)
	);

	// refused insert only happens with a full table and reports no coefficient
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_status |-> out_coef == '0 && out_cnt == CNT_W'(TABLE_DEPTH))
		else $error("refused insert with bad coefficient or count");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> out_cnt <= CNT_W'(TABLE_DEPTH))
		else $error("term count beyond table depth");

	// a new request is only taken right after a result slot was loaded or idle
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !s_tready)
		else $error("request taken while busy");

endmodule

`default_nettype wire
